// ----- sv/trf_pkg.sv -----
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants for the terminal reply filter
// Byte codes, result kinds, parser actions and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package trf_pkg;

  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h6e;

  localparam int unsigned DIGIT_SAT = 63;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_SCHEME = 2'd1,
    KIND_FG     = 2'd2,
    KIND_BG     = 2'd3
  } kind_e;

  // What one accepted byte asks of the block
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,  // byte held or consumed, no result
    ACT_BYTE  = 3'd1,  // pass the byte straight through
    ACT_REPLY = 3'd2,  // one reply, held bytes dropped
    ACT_FLUSH = 3'd3,  // byte held, then every held byte released
    ACT_FAIL  = 3'd4   // held bytes released, byte handled again from ground
  } action_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    logic [1:0]       scheme;
    logic [2:0][31:0] text;   // [0] red, [1] green, [2] blue
    logic [2:0][2:0]  len;
  } res_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_held;
    logic load_direct;
    logic load_tail;
    logic write_esc;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e action;
    logic    out_free;
    logic    flush_done;
    logic    tail_emit;
    logic    tail_esc;
  } dp_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic [7:0] lit_997_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_NINE;
      3'd1:    ch = CH_NINE;
      3'd2:    ch = 8'h37;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] lit_rgb_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h67;
      3'd2:    ch = 8'h62;
      3'd3:    ch = 8'h3a;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/trf_parse.sv -----
// ----------------------------------------------------------------------------
// trf_parse: sequence recognizer
// Tracks the parse state and reply accumulators, and decides per byte.
// ----------------------------------------------------------------------------
module trf_parse import trf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       at_limit_i,
  output action_e    action_o,
  output logic       hold_o,
  output res_t       res_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ESC      = 4'd1;
  localparam logic [3:0] ST_CSI_Q    = 4'd2;
  localparam logic [3:0] ST_CSI_LIT  = 4'd3;
  localparam logic [3:0] ST_CSI_SEMI = 4'd4;
  localparam logic [3:0] ST_CSI_NUM  = 4'd5;
  localparam logic [3:0] ST_OSC_1    = 4'd6;
  localparam logic [3:0] ST_OSC_2    = 4'd7;
  localparam logic [3:0] ST_OSC_SEMI = 4'd8;
  localparam logic [3:0] ST_OSC_LIT  = 4'd9;
  localparam logic [3:0] ST_COMP0    = 4'd10;
  localparam logic [3:0] ST_COMP1    = 4'd11;
  localparam logic [3:0] ST_COMP2    = 4'd12;
  localparam logic [3:0] ST_OSC_ST   = 4'd13;

  logic [3:0]       st_q, st_d;
  logic [2:0]       lit_idx_q, lit_idx_d;
  logic [5:0]       dig_cnt_q, dig_cnt_d;
  logic [7:0]       first_dig_q, first_dig_d;
  logic             bg_q, bg_d;
  logic [2:0][31:0] chars_q, chars_d;
  logic [2:0][2:0]  lens_q, lens_d;

  logic [1:0] k;
  logic [2:0] cur_len;
  logic       do_fail;
  logic       do_clear;
  logic       colour;
  logic       scheme_ok;

  assign k         = 2'(st_q - ST_COMP0);
  assign cur_len   = lens_q[k];
  assign scheme_ok = (dig_cnt_q == 6'd1) &&
                     (first_dig_q == CH_ONE || first_dig_q == CH_TWO);

  always_comb begin
    st_d        = st_q;
    lit_idx_d   = lit_idx_q;
    dig_cnt_d   = dig_cnt_q;
    first_dig_d = first_dig_q;
    bg_d        = bg_q;
    chars_d     = chars_q;
    lens_d      = lens_q;
    action_o    = ACT_NONE;
    hold_o      = 1'b0;
    do_fail     = 1'b0;
    do_clear    = 1'b0;
    colour      = 1'b0;

    case (st_q)
      ST_ESC: begin
        if (byte_i == CH_LBRACK) begin
          hold_o = 1'b1;
          st_d   = ST_CSI_Q;
        end else if (byte_i == CH_RBRACK) begin
          hold_o = 1'b1;
          st_d   = ST_OSC_1;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_CSI_Q: begin
        if (byte_i == CH_QUEST) begin
          hold_o    = 1'b1;
          lit_idx_d = 3'd0;
          st_d      = ST_CSI_LIT;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_CSI_LIT: begin
        if (lit_idx_q < 3'd3 && byte_i == lit_997_char(lit_idx_q)) begin
          hold_o    = 1'b1;
          lit_idx_d = lit_idx_q + 3'd1;
          if (lit_idx_q == 3'd2) st_d = ST_CSI_SEMI;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_CSI_SEMI: begin
        if (byte_i == CH_SEMI) begin
          hold_o      = 1'b1;
          dig_cnt_d   = '0;
          first_dig_d = '0;
          st_d        = ST_CSI_NUM;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_CSI_NUM: begin
        if (is_digit(byte_i)) begin
          hold_o = 1'b1;
          if (dig_cnt_q == '0) first_dig_d = byte_i;
          if (dig_cnt_q < 6'(DIGIT_SAT)) dig_cnt_d = dig_cnt_q + 6'd1;
        end else if (byte_i == CH_N) begin
          hold_o   = 1'b1;
          st_d     = ST_IDLE;
          do_clear = 1'b1;
          action_o = scheme_ok ? ACT_REPLY : ACT_FLUSH;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_OSC_1: begin
        if (byte_i == CH_ONE) begin
          hold_o = 1'b1;
          st_d   = ST_OSC_2;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_OSC_2: begin
        if (byte_i == CH_ZERO || byte_i == CH_ONE) begin
          hold_o = 1'b1;
          bg_d   = (byte_i == CH_ONE);
          st_d   = ST_OSC_SEMI;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_OSC_SEMI: begin
        if (byte_i == CH_SEMI) begin
          hold_o    = 1'b1;
          lit_idx_d = 3'd0;
          st_d      = ST_OSC_LIT;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_OSC_LIT: begin
        if (lit_idx_q < 3'd4 && byte_i == lit_rgb_char(lit_idx_q)) begin
          hold_o    = 1'b1;
          lit_idx_d = lit_idx_q + 3'd1;
          if (lit_idx_q == 3'd3) begin
            chars_d = '0;
            lens_d  = '0;
            st_d    = ST_COMP0;
          end
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_COMP0, ST_COMP1, ST_COMP2: begin
        if (is_hex(byte_i) && cur_len < 3'd4) begin
          hold_o    = 1'b1;
          lens_d[k] = cur_len + 3'd1;
          case (cur_len)
            3'd0:    chars_d[k][31:24] = byte_i;
            3'd1:    chars_d[k][23:16] = byte_i;
            3'd2:    chars_d[k][15:8]  = byte_i;
            default: chars_d[k][7:0]   = byte_i;
          endcase
        end else if (st_q != ST_COMP2 && byte_i == CH_SLASH && cur_len != '0) begin
          hold_o = 1'b1;
          st_d   = st_q + 4'd1;
        end else if (st_q == ST_COMP2 && byte_i == CH_BEL && cur_len != '0) begin
          colour   = 1'b1;
          action_o = ACT_REPLY;
          st_d     = ST_IDLE;
          do_clear = 1'b1;
        end else if (st_q == ST_COMP2 && byte_i == CH_ESC && cur_len != '0) begin
          hold_o = 1'b1;
          st_d   = ST_OSC_ST;
        end else begin
          do_fail = 1'b1;
        end
      end
      ST_OSC_ST: begin
        if (byte_i == CH_BSLASH) begin
          colour   = 1'b1;
          action_o = ACT_REPLY;
          st_d     = ST_IDLE;
          do_clear = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      default: begin
        // ground state, and any unused code falls back to it
        if (byte_i == CH_ESC) begin
          hold_o = 1'b1;
          st_d   = ST_ESC;
        end else begin
          st_d     = ST_IDLE;
          action_o = ACT_BYTE;
        end
      end
    endcase

    // failing byte is retried from ground; an ESC is re-held after the flush
    if (do_fail) begin
      hold_o   = 1'b0;
      action_o = ACT_FAIL;
      do_clear = 1'b1;
      st_d     = (byte_i == CH_ESC) ? ST_ESC : ST_IDLE;
    end

    if (action_o == ACT_NONE && hold_o && at_limit_i) begin
      action_o = ACT_FLUSH;
      st_d     = ST_IDLE;
      do_clear = 1'b1;
    end

    if (do_clear) begin
      lit_idx_d   = '0;
      dig_cnt_d   = '0;
      first_dig_d = '0;
      chars_d     = '0;
      lens_d      = '0;
    end
  end

  always_comb begin
    res_o = '0;
    if (action_o == ACT_BYTE) begin
      res_o.kind = KIND_BYTE;
      res_o.data = byte_i;
    end else if (colour) begin
      res_o.kind = bg_q ? KIND_BG : KIND_FG;
      res_o.text = chars_q;
      res_o.len  = lens_q;
    end else begin
      res_o.kind   = KIND_SCHEME;
      res_o.scheme = (first_dig_q == CH_ONE) ? 2'd1 : 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      lit_idx_q   <= '0;
      dig_cnt_q   <= '0;
      first_dig_q <= '0;
      bg_q        <= 1'b0;
      chars_q     <= '0;
      lens_q      <= '0;
    end else if (accept_i) begin
      st_q        <= st_d;
      lit_idx_q   <= lit_idx_d;
      dig_cnt_q   <= dig_cnt_d;
      first_dig_q <= first_dig_d;
      bg_q        <= bg_d;
      chars_q     <= chars_d;
      lens_q      <= lens_d;
    end
  end

endmodule

// ----- sv/trf_dp.sv -----
// ----------------------------------------------------------------------------
// trf_dp: datapath
// Parser, held-byte buffer with its count and read pointer, result register.
// ----------------------------------------------------------------------------
module trf_dp import trf_pkg::*; #(
  parameter int unsigned HELD_LIMIT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic       out_ready_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output res_t       out_res_o,
  output logic       out_last_o
);

  localparam int unsigned Depth = HELD_LIMIT + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);

  logic [7:0]    held_mem [Depth];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] count_q, count_d;
  logic [CW-1:0] flush_len_q;
  logic [CW-1:0] ptr_q;
  logic [7:0]    saved_q;
  logic          tail_emit_q;
  logic          tail_esc_q;
  logic          out_valid_q;
  res_t          out_res_q;
  logic          out_last_q;

  action_e       action;
  logic          hold;
  res_t          direct_res;
  logic          at_limit;
  logic          is_esc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          held_last;
  res_t          held_res;

  assign at_limit = (count_q == AW'(HELD_LIMIT));
  assign is_esc   = (in_byte_i == CH_ESC);

  trf_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (cmd_i.accept),
    .byte_i     (in_byte_i),
    .at_limit_i (at_limit),
    .action_o   (action),
    .hold_o     (hold),
    .res_o      (direct_res)
  );

  // One write port: held bytes at accept, re-held ESC after a failed prefix
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q;
    wr_data = in_byte_i;
    if (cmd_i.accept && hold) begin
      wr_en = 1'b1;
    end else if (cmd_i.write_esc) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = CH_ESC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) held_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_data_q <= held_mem[ptr_q[AW-1:0]];
  end

  always_comb begin
    case (action)
      ACT_NONE:  count_d = count_q + AW'(hold);
      ACT_FAIL:  count_d = is_esc ? AW'(1) : '0;
      ACT_BYTE:  count_d = count_q;
      default:   count_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      flush_len_q <= '0;
      ptr_q       <= '0;
      tail_emit_q <= 1'b0;
      tail_esc_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      count_q     <= count_d;
      flush_len_q <= (action == ACT_FLUSH) ? CW'(count_q) + CW'(1) : CW'(count_q);
      ptr_q       <= '0;
      tail_emit_q <= (action == ACT_FAIL) && !is_esc;
      tail_esc_q  <= (action == ACT_FAIL) && is_esc;
    end else if (cmd_i.load_held) begin
      ptr_q <= ptr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) saved_q <= in_byte_i;
  end

  assign held_last = (ptr_q + CW'(1) == flush_len_q) && !tail_emit_q;

  always_comb begin
    held_res      = '0;
    held_res.kind = KIND_BYTE;
    held_res.data = cmd_i.load_tail ? saved_q : rd_data_q;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_direct || cmd_i.load_held || cmd_i.load_tail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_direct) begin
      out_res_q  <= direct_res;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_held || cmd_i.load_tail) begin
      out_res_q  <= held_res;
      out_last_q <= cmd_i.load_tail ? 1'b1 : held_last;
    end
  end

  assign status_o.action     = action;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.flush_done = (ptr_q == flush_len_q);
  assign status_o.tail_emit  = tail_emit_q;
  assign status_o.tail_esc   = tail_esc_q;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- sv/trf_ctrl.sv -----
// ----------------------------------------------------------------------------
// trf_ctrl: controller
// Accepts bytes, sequences the release of held bytes and the trailing byte.
// ----------------------------------------------------------------------------
module trf_ctrl import trf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          case (status_i.action)
            ACT_BYTE, ACT_REPLY: cmd_o.load_direct = 1'b1;
            ACT_FLUSH, ACT_FAIL: state_d = S_RD;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (status_i.flush_done) begin
          state_d = S_TAIL;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_WR;
        end
      end
      S_WR: begin
        if (status_i.out_free) begin
          cmd_o.load_held = 1'b1;
          state_d         = S_RD;
        end
      end
      S_TAIL: begin
        if (status_i.tail_emit) begin
          if (status_i.out_free) begin
            cmd_o.load_tail = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.write_esc = status_i.tail_esc;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/terminal_reply_filter.sv -----
// ----------------------------------------------------------------------------
// terminal_reply_filter: terminal reply filter
// Passes terminal output through and extracts colour-scheme and colour replies.
// ----------------------------------------------------------------------------
// Takes one output byte per transaction. Bytes outside a candidate reply pass
// through to the result register. Bytes that may start a reply (ESC [ ? 997 ;
// digits n, or ESC ] 10/11 ;rgb: r/g/b ended by BEL or ESC \) are held and
// produce no result until the sequence resolves. A recognized reply is one
// result. A failed prefix, an unknown scheme number, or more than HELD_LIMIT
// held bytes releases the held bytes in order: the held buffer, with one write
// port and one registered read port, is read one entry at a time, and input is
// stalled meanwhile. last_of_run_o marks the final result caused by an input
// byte. The result register lets a new byte be taken in the cycle its
// predecessor's result is consumed.
module terminal_reply_filter import trf_pkg::*; #(
  parameter int unsigned HELD_LIMIT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  scheme_value_o,
  output logic [31:0] red_text_o,
  output logic [2:0]  red_len_o,
  output logic [31:0] green_text_o,
  output logic [2:0]  green_len_o,
  output logic [31:0] blue_text_o,
  output logic [2:0]  blue_len_o,
  output logic        last_of_run_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  res_t       res;

  trf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  trf_dp #(
    .HELD_LIMIT (HELD_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_byte_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_res_o   (res),
    .out_last_o  (last_of_run_o)
  );

  assign out_kind_o     = res.kind;
  assign out_byte_o     = res.data;
  assign scheme_value_o = res.scheme;
  assign red_text_o     = res.text[0];
  assign red_len_o      = res.len[0];
  assign green_text_o   = res.text[1];
  assign green_len_o    = res.len[1];
  assign blue_text_o    = res.text[2];
  assign blue_len_o     = res.len[2];

endmodule
